// File: hw/rtl/saf_pkg.sv
`timescale 1ns / 1ps

package saf_pkg;

  // Attitude, offset and motor position share one 11-bit signed format
  localparam int ANGLE_W = 11;
  localparam int MOVE_W  = 3;
  localparam int COUNT_W = 16;
  localparam int INDEX_W = 2;

  localparam int SAF_HALF_TURN = 900;

  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic signed [MOVE_W-1:0]  move_t;
  typedef logic [COUNT_W-1:0]        count_t;

  localparam count_t SETTLE_RESET = 16'd1000;

  localparam move_t MOVE_UP   = 3'sd2;
  localparam move_t MOVE_DOWN = -3'sd2;
  localparam move_t MOVE_NONE = 3'sd0;

  // Register indexes on the configuration channel
  localparam logic [INDEX_W-1:0] REG_SETTLE_TICKS = 2'd0;
  localparam logic [INDEX_W-1:0] REG_PITCH_OFFSET = 2'd1;
  localparam logic [INDEX_W-1:0] REG_ROLL_OFFSET  = 2'd2;
  localparam logic [INDEX_W-1:0] REG_YAW_OFFSET   = 2'd3;

  typedef struct packed {
    count_t settle_ticks;
    angle_t pitch_offset;
    angle_t roll_offset;
    angle_t yaw_offset;
  } cfg_regs_t;

endpackage

// File: hw/rtl/saf_cfg.sv
`timescale 1ns / 1ps

module saf_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [saf_pkg::INDEX_W-1:0]  cfg_index,
  input  logic [saf_pkg::COUNT_W-1:0]  cfg_data,
  output saf_pkg::cfg_regs_t           regs
);
  import saf_pkg::*;

  cfg_regs_t regs_next;

  assign cfg_ready = 1'b1;

  always_comb begin
    regs_next = regs;
    if (cfg_valid) begin
      case (cfg_index)
        REG_SETTLE_TICKS: regs_next.settle_ticks = cfg_data;
        REG_PITCH_OFFSET: regs_next.pitch_offset = cfg_data[ANGLE_W-1:0];
        REG_ROLL_OFFSET:  regs_next.roll_offset  = cfg_data[ANGLE_W-1:0];
        REG_YAW_OFFSET:   regs_next.yaw_offset   = cfg_data[ANGLE_W-1:0];
        default:          regs_next = regs;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.settle_ticks <= SETTLE_RESET;
      regs.pitch_offset <= '0;
      regs.roll_offset  <= '0;
      regs.yaw_offset   <= '0;
    end else begin
      regs <= regs_next;
    end
  end

endmodule

// File: hw/rtl/saf_axis.sv
`timescale 1ns / 1ps

module saf_axis #(
  parameter int HALF_TURN = saf_pkg::SAF_HALF_TURN
) (
  input  saf_pkg::angle_t motor,
  input  saf_pkg::angle_t angle,
  input  saf_pkg::angle_t offset,
  output saf_pkg::move_t  move_a,
  output saf_pkg::move_t  move_b,
  output saf_pkg::angle_t motor_next
);
  import saf_pkg::*;

  // Wide enough for target, motor and their difference at any half turn
  localparam int AW = $clog2(2 * HALF_TURN + 4100) + 2;
  localparam logic signed [AW-1:0] H    = AW'(HALF_TURN);
  localparam logic signed [AW-1:0] TWO  = AW'(2);
  localparam logic signed [AW-1:0] ONE  = AW'(1);

  logic signed [AW-1:0] angle_x;
  logic signed [AW-1:0] offset_x;
  logic signed [AW-1:0] sum;
  logic signed [AW-1:0] wrap_hi;
  logic signed [AW-1:0] target;
  logic signed [AW-1:0] m0;
  logic signed [AW-1:0] m1;
  logic signed [AW-1:0] m2;
  logic signed [AW-1:0] up;
  logic signed [AW-1:0] down;

  assign angle_x  = {{(AW-ANGLE_W){angle[ANGLE_W-1]}}, angle};
  assign offset_x = {{(AW-ANGLE_W){offset[ANGLE_W-1]}}, offset};
  assign m0       = {{(AW-ANGLE_W){motor[ANGLE_W-1]}}, motor};

  // Wrap the target once from each side
  always_comb begin
    sum     = angle_x + offset_x;
    wrap_hi = (sum > H) ? sum - (H + H) : sum;
    target  = (wrap_hi < -H) ? wrap_hi + (H + H) : wrap_hi;
  end

  // First compare: motor ahead of target
  always_comb begin
    move_a = MOVE_NONE;
    m1     = m0;
    up     = m0 + TWO;
    if (m0 > target) begin
      if (m0 - target > H) begin
        move_a = MOVE_UP;
        m1     = (up > H) ? ONE - H : up;
      end else begin
        move_a = MOVE_DOWN;
        m1     = m0 - TWO;
      end
    end
  end

  // Second compare on the updated position: motor behind target
  always_comb begin
    move_b = MOVE_NONE;
    m2     = m1;
    down   = m1 - TWO;
    if (m1 < target) begin
      if (target - m1 > H) begin
        move_b = MOVE_DOWN;
        m2     = (down < -H) ? H - ONE : down;
      end else begin
        move_b = MOVE_UP;
        m2     = m1 + TWO;
      end
    end
  end

  assign motor_next = m2[ANGLE_W-1:0];

endmodule

// File: hw/rtl/stepper_angle_follower.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake            Payload
// s_axis    in   s_tvalid/s_tready    s_tdata: pitch, roll, yaw angle
// m_axis    out  m_tvalid/m_tready    m_tdata: moves and positions, m_tuser: tracking
// cfg       in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One tick per cycle unless m_tready stalls: axis compares and wrap are combinational
// before the result register, so a result appears in the cycle after accept.
// s_tready is high whenever the result register is empty or is being drained.
// A stalled m_tready holds the result and blocks only new ticks.
// Synchronous reset clears the tick counter, the tracking flag and motor positions
// and loads the register defaults; cfg_ready is always high.

module stepper_angle_follower #(
  parameter int HALF_TURN = saf_pkg::SAF_HALF_TURN
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [39:0]                 s_tdata,   // pitch_angle, roll_angle, yaw_angle
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // pitch_move_a, pitch_move_b, roll_move_a, roll_move_b, yaw_move_a, yaw_move_b,
  // pitch_position, roll_position, yaw_position
  output logic [55:0]                 m_tdata,
  output logic                        m_tuser,   // tracking
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [saf_pkg::INDEX_W-1:0] cfg_index,
  input  logic [saf_pkg::COUNT_W-1:0] cfg_data
);
  import saf_pkg::*;

  cfg_regs_t regs;
  logic      accept;

  angle_t pitch_angle, roll_angle, yaw_angle;
  angle_t pitch_motor, roll_motor, yaw_motor;
  angle_t pitch_next, roll_next, yaw_next;
  move_t  pitch_a, pitch_b, roll_a, roll_b, yaw_a, yaw_b;
  count_t settle_count;
  logic   is_tracking;

  saf_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  assign pitch_angle = s_tdata[10:0];
  assign roll_angle  = s_tdata[21:11];
  assign yaw_angle   = s_tdata[32:22];

  saf_axis #(.HALF_TURN(HALF_TURN)) u_pitch (
    .motor(pitch_motor), .angle(pitch_angle), .offset(regs.pitch_offset),
    .move_a(pitch_a), .move_b(pitch_b), .motor_next(pitch_next)
  );

  saf_axis #(.HALF_TURN(HALF_TURN)) u_roll (
    .motor(roll_motor), .angle(roll_angle), .offset(regs.roll_offset),
    .move_a(roll_a), .move_b(roll_b), .motor_next(roll_next)
  );

  saf_axis #(.HALF_TURN(HALF_TURN)) u_yaw (
    .motor(yaw_motor), .angle(yaw_angle), .offset(regs.yaw_offset),
    .move_a(yaw_a), .move_b(yaw_b), .motor_next(yaw_next)
  );

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // Tick state
  always_ff @(posedge clk) begin
    if (rst) begin
      settle_count <= '0;
      is_tracking  <= 1'b0;
      pitch_motor  <= '0;
      roll_motor   <= '0;
      yaw_motor    <= '0;
    end else if (accept) begin
      if (!is_tracking) begin
        if (settle_count < regs.settle_ticks) begin
          settle_count <= settle_count + 1'b1;
        end else begin
          is_tracking <= 1'b1;
          pitch_motor <= pitch_angle;
          roll_motor  <= roll_angle;
          yaw_motor   <= yaw_angle;
        end
      end else begin
        pitch_motor <= pitch_next;
        roll_motor  <= roll_next;
        yaw_motor   <= yaw_next;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata[55:51] <= '0;
      if (!is_tracking) begin
        m_tdata[17:0] <= '0;
        if (settle_count < regs.settle_ticks) begin
          m_tuser        <= 1'b0;
          m_tdata[28:18] <= pitch_motor;
          m_tdata[39:29] <= roll_motor;
          m_tdata[50:40] <= yaw_motor;
        end else begin
          m_tuser        <= 1'b1;
          m_tdata[28:18] <= pitch_angle;
          m_tdata[39:29] <= roll_angle;
          m_tdata[50:40] <= yaw_angle;
        end
      end else begin
        m_tuser        <= 1'b1;
        m_tdata[17:0]  <= {yaw_b, yaw_a, roll_b, roll_a, pitch_b, pitch_a};
        m_tdata[28:18] <= pitch_next;
        m_tdata[39:29] <= roll_next;
        m_tdata[50:40] <= yaw_next;
      end
    end
  end

endmodule

// File: bench/stepper_angle_follower_test.sv
`timescale 1ns / 1ps

module stepper_angle_follower_test;
  import saf_pkg::*;

  localparam int PERIOD = 4;
  localparam int HALF   = SAF_HALF_TURN;

  // s_tdata layout, lowest bits last in the list
  typedef struct packed {
    logic [6:0] pad;
    angle_t     yaw;
    angle_t     roll;
    angle_t     pitch;
  } attitude_t;

  // m_tdata layout, lowest bits last in the list
  typedef struct packed {
    logic [4:0] pad;
    angle_t     yaw_pos;
    angle_t     roll_pos;
    angle_t     pitch_pos;
    move_t      yaw_b;
    move_t      yaw_a;
    move_t      roll_b;
    move_t      roll_a;
    move_t      pitch_b;
    move_t      pitch_a;
  } step_bits_t;

  typedef struct packed {
    logic       tracking;
    step_bits_t bits;
  } step_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [39:0]        s_tdata = '0;   // pitch_angle, roll_angle, yaw_angle
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  // pitch_move_a, pitch_move_b, roll_move_a, roll_move_b, yaw_move_a, yaw_move_b,
  // pitch_position, roll_position, yaw_position
  logic [55:0]        m_tdata;
  logic               m_tuser;        // tracking
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [INDEX_W-1:0] cfg_index = '0;
  logic [COUNT_W-1:0] cfg_data = '0;

  stepper_angle_follower u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(PERIOD / 2) clk = ~clk;

  attitude_t    attitude_pending[$];
  step_result_t step_expected[$];

  // Follower state as predicted from accepted ticks and register writes
  count_t settle_limit = SETTLE_RESET;
  count_t settle_cnt   = '0;
  logic   following    = 1'b0;
  angle_t pitch_motor  = '0;
  angle_t roll_motor   = '0;
  angle_t yaw_motor    = '0;
  angle_t pitch_off    = '0;
  angle_t roll_off     = '0;
  angle_t yaw_off      = '0;

  bit tick_taken = 1'b0;
  bit calm       = 1'b0;
  int mismatches = 0;
  int ticks_in   = 0;
  int results    = 0;
  int moved      = 0;

  task automatic track_axis(inout angle_t motor, input angle_t angle, input angle_t offset,
                            output move_t mv_a, output move_t mv_b);
    int t;
    int m;
    t = int'(angle) + int'(offset);
    m = int'(motor);
    mv_a = MOVE_NONE;
    mv_b = MOVE_NONE;
    // wrap only once from each side; this already brings the target into range
    if (t > HALF) t -= 2 * HALF;
    if (t < -HALF) t += 2 * HALF;
    if (m > t) begin
      if (m - t > HALF) begin
        m += 2;
        mv_a = MOVE_UP;
        if (m > HALF) m = -HALF + 1;
      end else begin
        m -= 2;
        mv_a = MOVE_DOWN;
      end
    end
    if (m < t) begin
      if (t - m > HALF) begin
        m -= 2;
        mv_b = MOVE_DOWN;
        if (m < -HALF) m = HALF - 1;
      end else begin
        m += 2;
        mv_b = MOVE_UP;
      end
    end
    motor = angle_t'(m);
  endtask

  task automatic predict_step(input attitude_t a);
    step_result_t r;
    r = '0;
    if (!following) begin
      if (settle_cnt < settle_limit) begin
        settle_cnt = settle_cnt + 1'b1;
      end else begin
        following = 1'b1;
        pitch_motor = a.pitch;
        roll_motor = a.roll;
        yaw_motor = a.yaw;
      end
    end else begin
      track_axis(pitch_motor, a.pitch, pitch_off, r.bits.pitch_a, r.bits.pitch_b);
      track_axis(roll_motor, a.roll, roll_off, r.bits.roll_a, r.bits.roll_b);
      track_axis(yaw_motor, a.yaw, yaw_off, r.bits.yaw_a, r.bits.yaw_b);
    end
    r.tracking = following;
    r.bits.pitch_pos = pitch_motor;
    r.bits.roll_pos = roll_motor;
    r.bits.yaw_pos = yaw_motor;
    step_expected.push_back(r);
  endtask

  function automatic void compare_field(string name, int expv, int actv);
    if (expv != actv) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, name, expv, actv);
    end
  endfunction

  // Monitor: sample all three handshakes at the rising edge
  always @(posedge clk) begin
    step_result_t want;
    step_bits_t   got;
    tick_taken = !rst && s_tvalid && s_tready;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SETTLE_TICKS: settle_limit = cfg_data;
          REG_PITCH_OFFSET: pitch_off = angle_t'(cfg_data[ANGLE_W-1:0]);
          REG_ROLL_OFFSET:  roll_off = angle_t'(cfg_data[ANGLE_W-1:0]);
          REG_YAW_OFFSET:   yaw_off = angle_t'(cfg_data[ANGLE_W-1:0]);
          default: ;
        endcase
      end
      if (tick_taken) begin
        predict_step(attitude_t'(s_tdata));
        ticks_in++;
      end
      if (m_tvalid && m_tready) begin
        results++;
        got = step_bits_t'(m_tdata);
        if (step_expected.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing expected: tdata %h tuser %b",
                   $time, m_tdata, m_tuser);
        end else begin
          want = step_expected.pop_front();
          if (want.bits[17:0] != '0) moved++;
          compare_field("tracking", want.tracking, m_tuser);
          compare_field("pitch_move_a", want.bits.pitch_a, got.pitch_a);
          compare_field("pitch_move_b", want.bits.pitch_b, got.pitch_b);
          compare_field("roll_move_a", want.bits.roll_a, got.roll_a);
          compare_field("roll_move_b", want.bits.roll_b, got.roll_b);
          compare_field("yaw_move_a", want.bits.yaw_a, got.yaw_a);
          compare_field("yaw_move_b", want.bits.yaw_b, got.yaw_b);
          compare_field("pitch_position", want.bits.pitch_pos, got.pitch_pos);
          compare_field("roll_position", want.bits.roll_pos, got.roll_pos);
          compare_field("yaw_position", want.bits.yaw_pos, got.yaw_pos);
          compare_field("tdata padding", 0, got.pad);
        end
      end
    end
  end

  // Driver: advance the request and the result stall at the falling edge
  always @(negedge clk) begin
    if (!rst) begin
      if (!s_tvalid || tick_taken) begin
        if (attitude_pending.size() != 0 && (calm || $urandom_range(0, 99) >= 11)) begin
          s_tdata <= attitude_pending.pop_front();
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= calm || ($urandom_range(0, 99) >= 11);
    end
  end

  task automatic push_tick(input int p, input int r, input int y);
    attitude_t a;
    a = '0;
    a.pitch = angle_t'(p);
    a.roll = angle_t'(r);
    a.yaw = angle_t'(y);
    attitude_pending.push_back(a);
  endtask

  task automatic write_reg(input logic [INDEX_W-1:0] idx, input count_t value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (attitude_pending.size() != 0 || s_tvalid || step_expected.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic count_t pick_offset();
    int v;
    case ($urandom_range(0, 9))
      0: v = -HALF;
      1: v = HALF;
      2: v = 0;
      3: v = $urandom;   // stray upper bits and out-of-range values
      default: v = int'($urandom_range(0, 2 * HALF)) - HALF;
    endcase
    return count_t'(v);
  endfunction

  function automatic int next_angle(inout int walker, input int mode);
    walker += int'($urandom_range(0, 6)) - 3;
    if (walker > HALF) walker -= 2 * HALF;
    if (walker < -HALF) walker += 2 * HALF;
    case (mode)
      0: return int'($urandom_range(0, 2 * HALF)) - HALF;
      1: return int'(angle_t'($urandom));
      default: return walker;
    endcase
  endfunction

  initial begin
    int wp;
    int wr;
    int wy;
    int mode;
    count_t limit;
    wp = 0;
    wr = 0;
    wy = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Settling under the reset count, then the largest count, then zero
    push_tick($urandom, $urandom, $urandom);
    push_tick($urandom, $urandom, $urandom);
    drain();
    write_reg(REG_SETTLE_TICKS, 16'hFFFF);
    push_tick($urandom, $urandom, $urandom);
    push_tick($urandom, $urandom, $urandom);
    drain();
    write_reg(REG_SETTLE_TICKS, 16'd0);
    // load tick, then targets across the half turn to force the wrapped moves
    push_tick(899, -899, 0);
    push_tick(-900, 900, 1023);
    push_tick(900, -900, -1024);
    push_tick(1023, -1024, 0);
    push_tick(0, 0, 0);
    push_tick(0, 0, 0);
    push_tick(1, -1, 2);
    drain();
    write_reg(REG_PITCH_OFFSET, count_t'(HALF));
    write_reg(REG_ROLL_OFFSET, count_t'(-HALF));
    write_reg(REG_YAW_OFFSET, 16'd1023);
    push_tick(900, -900, 1023);
    push_tick(-900, 900, -1024);
    push_tick(0, 0, 0);
    drain();
    write_reg(REG_PITCH_OFFSET, 16'hFC00);
    write_reg(REG_ROLL_OFFSET, 16'h03FF);
    write_reg(REG_YAW_OFFSET, 16'h0000);
    push_tick(-1024, 1023, -900);
    push_tick(1023, -1024, 900);
    push_tick(-900, 900, 0);
    drain();

    // Mostly slow drifting targets so the motors catch up, with jumps and raw noise
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: limit = 16'hFFFF;
        1: limit = 16'h0000;
        default: limit = count_t'($urandom);
      endcase
      write_reg(REG_SETTLE_TICKS, limit);
      write_reg(REG_PITCH_OFFSET, pick_offset());
      write_reg(REG_ROLL_OFFSET, pick_offset());
      write_reg(REG_YAW_OFFSET, pick_offset());
      calm = (p == 3);
      for (int i = 0; i < 50; i++) begin
        mode = ($urandom_range(0, 99) < 15) ? 0 : ($urandom_range(0, 99) < 15) ? 1 : 2;
        push_tick(next_angle(wp, mode), next_angle(wr, mode), next_angle(wy, mode));
      end
      drain();
    end
    calm = 1'b0;

    repeat (10) @(posedge clk);
    $display("Ran %0d ticks through settling, load and 8 offset settings;", ticks_in);
    $display("%0d results checked, %0d of them with motor steps.", results, moved);
    if (mismatches == 0 && step_expected.size() == 0) begin
      $display("[stepper_angle_follower] OK");
    end else begin
      $display("[stepper_angle_follower] ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timed out with %0d results outstanding", step_expected.size());
    $display("[stepper_angle_follower] ERROR");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/saf_pkg.sv
hw/rtl/saf_cfg.sv
hw/rtl/saf_axis.sv
hw/rtl/stepper_angle_follower.sv
bench/stepper_angle_follower_test.sv
